>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed: %m");

// Next-cycle implication, disabled while reset is asserted.
`define SSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed: %m");

`endif

>>> src/ssp_pkg.sv
// Shared types and constants of the servo status packet parser.
// No dependencies; imported by every module of the block.
package ssp_pkg;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} ssp_in_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] servo_id;
		logic [7:0] servo_error;
		logic [4:0] param_count;
		logic [3:0] param_index;
		logic [7:0] param_byte;
		logic       last;
	} ssp_out_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOREPLY = 3'd1,
		ST_TIMEOUT = 3'd2,
		ST_INVALID = 3'd3,
		ST_SERVO   = 3'd4,
		ST_BADSUM  = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		PH_HEAD1,
		PH_HEAD2,
		PH_ID,
		PH_LEN,
		PH_ERR,
		PH_PARAM,
		PH_CHK,
		PH_READ,
		PH_EMIT
	} phase_t;

	localparam logic [7:0] HEADER_BYTE  = 8'hFF;
	localparam logic [7:0] LEN_OVERHEAD = 8'd2;

	// Controller to datapath.
	typedef struct packed {
		logic    load_id;
		logic    load_len;
		logic    add_err;
		logic    store_param;
		logic    restart;
		logic    emit_fail;
		status_t fail_status;
		logic    emit_ok;
		logic    burst_start;
		logic    burst_emit;
	} ssp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_free;
		logic timeout;
		logic byte_ff;
		logic byte_zero;
		logic len_ok;
		logic exp_zero;
		logic params_done;
		logic sum_ok;
		logic burst_last;
	} ssp_stat_t;

endpackage

>>> src/ssp_ctrl.sv
// Packet phase state machine of the servo status packet parser.
// Depends on ssp_pkg; drives commands into ssp_datapath.
module ssp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  ssp_pkg::ssp_stat_t stat,
	output ssp_pkg::ssp_cmd_t  cmd,
	output logic              ready
);
	import ssp_pkg::*;

	phase_t state_q;
	phase_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_HEAD1;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.fail_status = ST_OK;
		ready           = 1'b0;
		case (state_q)
			PH_READ: begin
				// wait for the store read
				state_d = PH_EMIT;
			end
			PH_EMIT: begin
				if (stat.out_free) begin
					cmd.burst_emit = 1'b1;
					if (stat.burst_last) begin
						cmd.restart = 1'b1;
						state_d     = PH_HEAD1;
					end else begin
						state_d = PH_READ;
					end
				end
			end
			default: begin
				ready = stat.out_free;
				if (item_valid && stat.out_free) begin
					if (stat.timeout) begin
						cmd.emit_fail = 1'b1;
						cmd.restart   = 1'b1;
						state_d       = PH_HEAD1;
						case (state_q)
							PH_HEAD1: cmd.fail_status = ST_NOREPLY;
							PH_CHK:   cmd.fail_status = ST_BADSUM;
							default:  cmd.fail_status = ST_TIMEOUT;
						endcase
					end else begin
						case (state_q)
							PH_HEAD1: begin
								if (stat.byte_ff) begin
									state_d = PH_HEAD2;
								end else begin
									cmd.emit_fail   = 1'b1;
									cmd.fail_status = ST_INVALID;
									cmd.restart     = 1'b1;
									state_d         = PH_HEAD1;
								end
							end
							PH_HEAD2: begin
								if (stat.byte_ff) begin
									state_d = PH_ID;
								end else begin
									cmd.emit_fail   = 1'b1;
									cmd.fail_status = ST_INVALID;
									cmd.restart     = 1'b1;
									state_d         = PH_HEAD1;
								end
							end
							PH_ID: begin
								cmd.load_id = 1'b1;
								state_d     = PH_LEN;
							end
							PH_LEN: begin
								if (stat.len_ok) begin
									cmd.load_len = 1'b1;
									state_d      = PH_ERR;
								end else begin
									cmd.emit_fail   = 1'b1;
									cmd.fail_status = ST_INVALID;
									cmd.restart     = 1'b1;
									state_d         = PH_HEAD1;
								end
							end
							PH_ERR: begin
								if (stat.byte_zero) begin
									cmd.add_err = 1'b1;
									state_d     = stat.exp_zero ? PH_CHK : PH_PARAM;
								end else begin
									cmd.emit_fail   = 1'b1;
									cmd.fail_status = ST_SERVO;
									cmd.restart     = 1'b1;
									state_d         = PH_HEAD1;
								end
							end
							PH_PARAM: begin
								cmd.store_param = 1'b1;
								if (stat.params_done) begin
									state_d = PH_CHK;
								end
							end
							PH_CHK: begin
								if (!stat.sum_ok) begin
									cmd.emit_fail   = 1'b1;
									cmd.fail_status = ST_BADSUM;
									cmd.restart     = 1'b1;
									state_d         = PH_HEAD1;
								end else if (stat.exp_zero) begin
									cmd.emit_ok = 1'b1;
									cmd.restart = 1'b1;
									state_d     = PH_HEAD1;
								end else begin
									cmd.burst_start = 1'b1;
									state_d         = PH_READ;
								end
							end
							default: begin
								cmd.restart = 1'b1;
								state_d     = PH_HEAD1;
							end
						endcase
					end
				end
			end
		endcase
	end

endmodule

>>> src/ssp_datapath.sv
// Datapath of the servo status packet parser: packet fields, checksum,
// parameter store and result register. Depends on ssp_pkg; driven by ssp_ctrl.
module ssp_datapath #(
	parameter int MAX_PARAMS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ssp_pkg::ssp_in_t   item,
	input  ssp_pkg::ssp_cmd_t  cmd,
	output ssp_pkg::ssp_stat_t stat,
	output logic               result_valid,
	input  logic               result_stall,
	output ssp_pkg::ssp_out_t  result
);
	import ssp_pkg::*;

	localparam int CNT_W = $clog2(MAX_PARAMS + 1);
	localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

	logic [7:0]       id_q;
	logic [7:0]       sum_q;
	logic [CNT_W-1:0] exp_q;
	logic [CNT_W-1:0] rcv_q;
	logic [CNT_W-1:0] k_q;
	logic [7:0]       store_q [MAX_PARAMS];
	logic [7:0]       rd_q;
	logic             out_valid_q;
	ssp_out_t         out_q;

	logic [7:0]       b;
	logic [7:0]       n8;
	logic [CNT_W+4:0] cnt_ext;
	logic [CNT_W+4:0] k_ext;
	logic             load_out;
	ssp_out_t         out_d;

	assign b       = item.rx_byte;
	assign n8      = b - LEN_OVERHEAD;
	assign cnt_ext = (CNT_W + 5)'(exp_q);
	assign k_ext   = (CNT_W + 5)'(k_q);

	assign stat.out_free    = !out_valid_q || !result_stall;
	assign stat.timeout     = item.cmd;
	assign stat.byte_ff     = (b == HEADER_BYTE);
	assign stat.byte_zero   = (b == 8'd0);
	assign stat.len_ok      = ({1'b0, n8} <= 9'(MAX_PARAMS));
	assign stat.exp_zero    = (exp_q == '0);
	assign stat.params_done = ((rcv_q + CNT_W'(1)) == exp_q);
	assign stat.sum_ok      = (b == ~sum_q);
	assign stat.burst_last  = ((k_q + CNT_W'(1)) == exp_q);

	assign load_out = cmd.emit_fail || cmd.emit_ok || cmd.burst_emit;

	always_comb begin
		out_d             = '0;
		out_d.status      = cmd.emit_fail ? cmd.fail_status : ST_OK;
		out_d.servo_id    = id_q;
		out_d.servo_error = (cmd.emit_fail && cmd.fail_status == ST_SERVO) ? b : 8'd0;
		out_d.param_count = cnt_ext[4:0];
		out_d.param_index = cmd.burst_emit ? k_ext[3:0] : 4'd0;
		out_d.param_byte  = cmd.burst_emit ? rd_q : 8'd0;
		out_d.last        = cmd.burst_emit ? stat.burst_last : 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q        <= '0;
			sum_q       <= '0;
			exp_q       <= '0;
			rcv_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_id) begin
				id_q  <= b;
				sum_q <= b;
			end
			if (cmd.load_len) begin
				exp_q <= n8[CNT_W-1:0];
				rcv_q <= '0;
				sum_q <= sum_q + b;
			end
			if (cmd.add_err) begin
				sum_q <= sum_q + b;
			end
			if (cmd.store_param) begin
				sum_q <= sum_q + b;
				rcv_q <= rcv_q + CNT_W'(1);
			end
			if (cmd.burst_start) begin
				k_q <= '0;
			end
			if (cmd.burst_emit && !cmd.restart) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (cmd.restart) begin
				id_q  <= '0;
				sum_q <= '0;
				exp_q <= '0;
				rcv_q <= '0;
				k_q   <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// parameter store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.store_param) begin
			store_q[rcv_q[IDX_W-1:0]] <= b;
		end
		rd_q <= store_q[k_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

>>> src/servo_status_packet_parser.sv
// Top level of the servo status packet parser.
// Depends on ssp_pkg, ssp_ctrl and ssp_datapath.
//
// Usage:
//   item channel (item_valid / item_stall / item): one received reply byte
//   per transfer, or a receive-timeout event when item.cmd is set.
//   result channel (result_valid / result_stall / result): status results.
//   A packet is 0xFF 0xFF id length error params checksum.
//   A failure (no reply, timeout, invalid, servo error, bad checksum) gives
//   one result, visible the cycle after the byte that causes it.
//   A good packet with no parameters gives one result likewise. A good packet
//   with parameters gives one result per parameter after the checksum
//   transfer, each after a registered read of the parameter store
//   (PH_READ, then PH_EMIT). Bytes that cause no result stall nothing.
//   The item side stalls while the parameter burst is sent and while a held
//   result blocks the result register.
//   When result_stall is high the result register holds its value, and
//   bytes are taken only once the register frees up.
//   Reset (arst_n low) returns the parser to waiting for the first header and
//   drops any pending result. The parameter store needs no clearing.
module servo_status_packet_parser #(
	parameter int MAX_PARAMS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  ssp_pkg::ssp_in_t  item,
	output logic              result_valid,
	input  logic              result_stall,
	output ssp_pkg::ssp_out_t result
);
	import ssp_pkg::*;

	ssp_cmd_t  cmd;
	ssp_stat_t stat;
	logic      ready;

	// phase tracking and sequencing of the parameter burst
	ssp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.stat       (stat),
		.cmd        (cmd),
		.ready      (ready)
	);

	// packet fields, checksum, parameter store, result register
	ssp_datapath #(
		.MAX_PARAMS (MAX_PARAMS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// stall the byte stream whenever the controller cannot take a transfer
	assign item_stall = !ready;

endmodule

>>> src/ssp_checker.sv
// Port-level checks of the servo status packet parser, bound to the top.
// Depends on ssp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ssp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input ssp_pkg::ssp_in_t  item,
	input logic              result_valid,
	input logic              result_stall,
	input ssp_pkg::ssp_out_t result
);
	import ssp_pkg::*;

	// a stalled result holds
	`SSP_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall,
		result_valid && $stable(result))

	`SSP_ASSERT_SAME(a_status_range, clk, arst_n, result_valid, result.status <= 3'd5)

	// a failure is a single result with no parameter
	`SSP_ASSERT_SAME(a_fail_single, clk, arst_n, result_valid && result.status != ST_OK,
		result.last && result.param_index == 4'd0 && result.param_byte == 8'd0)

	`SSP_ASSERT_SAME(a_servo_err, clk, arst_n, result_valid && result.status == ST_SERVO,
		result.servo_error != 8'd0)

	// a timeout transfer reports a failure in the next cycle
	`SSP_ASSERT_NEXT(a_timeout_result, clk, arst_n, item_valid && !item_stall && item.cmd,
		result_valid && result.last && result.status != ST_OK)

endmodule

bind servo_status_packet_parser ssp_checker u_ssp_checker (.*);
